### src/gbf_pkg.sv
// Shared types and constants for the graph bridge finder.
// Holds the controller states, datapath commands and status struct.
// No dependencies.
`timescale 1ns / 1ps

package gbf_pkg;

  localparam int FieldW  = 5;
  localparam int CountW  = 6;
  localparam int MaxEmit = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROOT,
    ST_LOAD,
    ST_SCAN,
    ST_POP,
    ST_HDR,
    ST_FIND,
    ST_BR,
    ST_CLEAR
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_INIT,
    OP_ROOT,
    OP_LOAD,
    OP_SCAN,
    OP_POP,
    OP_HDR_NEXT,
    OP_FIND,
    OP_BR_NEXT,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic root_end;
    logic root_seen;
    logic scan_end;
    logic scan_hit;
    logic depth_zero;
    logic find_hit;
    logic emit_zero;
    logic emit_last;
  } dp_status_t;

endpackage

### src/gbf_ctrl.sv
// Controller state machine for the graph bridge finder.
// Depends on gbf_pkg; drives gbf_datapath through commands and status.
`timescale 1ns / 1ps

module gbf_ctrl import gbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_run,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_bridge,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_op_t     op
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_bridge = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_run) begin
            state_next = ST_INIT;
          end else begin
            op = OP_ADD;
          end
        end
      end
      ST_INIT: begin
        op         = OP_INIT;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (st.root_end) begin
          state_next = ST_HDR;
        end else begin
          op = OP_ROOT;
          if (!st.root_seen) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        op         = OP_LOAD;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        op = OP_SCAN;
        if (st.scan_end) begin
          state_next = ST_POP;
        end else if (st.scan_hit) begin
          state_next = ST_LOAD;
        end
      end
      ST_POP: begin
        op         = OP_POP;
        state_next = st.depth_zero ? ST_ROOT : ST_LOAD;
      end
      ST_HDR: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op         = OP_HDR_NEXT;
          state_next = st.emit_zero ? ST_CLEAR : ST_FIND;
        end
      end
      ST_FIND: begin
        if (st.find_hit) begin
          state_next = ST_BR;
        end else begin
          op = OP_FIND;
        end
      end
      ST_BR: begin
        out_valid  = 1'b1;
        out_bridge = 1'b1;
        if (out_ready) begin
          op         = OP_BR_NEXT;
          state_next = st.emit_last ? ST_CLEAR : ST_FIND;
        end
      end
      ST_CLEAR: begin
        op         = OP_CLEAR;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output both open");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && in_run) |=> (state == ST_INIT))
    else $error("run beat did not start the search");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HDR && out_ready && st.emit_zero) |=> (state == ST_CLEAR))
    else $error("empty run did not end after header");
`endif

endmodule

### src/gbf_datapath.sv
// Datapath for the graph bridge finder: matrix, search stack, marks.
// Depends on gbf_pkg; commanded by gbf_ctrl.
`timescale 1ns / 1ps

module gbf_datapath import gbf_pkg::*; #(
  parameter int NODES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_op_t            op,
  input  logic [FieldW-1:0] node_a,
  input  logic [FieldW-1:0] node_b,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_value,
  output dp_status_t        st,
  output logic [FieldW-1:0] bridge_count,
  output logic [FieldW-1:0] low_end,
  output logic [FieldW-1:0] high_end
);

  localparam int NW   = $clog2(NODES);
  localparam int CW   = $clog2(NODES + 1);
  localparam int CMPW = 8;

  logic [NODES-1:0] adj [NODES];
  logic [NODES-1:0] bmark [NODES];
  logic [CW-1:0]    disc [NODES];
  logic [CW-1:0]    low [NODES];
  logic [NW-1:0]    snode [NODES];
  logic [NW-1:0]    spar [NODES];
  logic [CW-1:0]    sscan [NODES];

  logic [CountW-1:0] node_count;
  logic [CW-1:0]     depth, tcnt, root, x, count;
  logic [NW-1:0]     v, par, top, lo, hi;
  logic [FieldW-1:0] k, emitted;
  logic [CW-1:0]     neff;
  logic [NW-1:0]     xi, u;
  logic              a_ok, b_ok;

  // Effective node count and range checks.
  assign neff = (CMPW'(node_count) > CMPW'(NODES)) ? CW'(NODES) : CW'(node_count);
  assign a_ok = CMPW'(node_a) < CMPW'(neff);
  assign b_ok = CMPW'(node_b) < CMPW'(neff);
  assign xi   = x[NW-1:0];
  assign u    = NW'(depth - CW'(1));
  assign emitted = (CMPW'(count) > CMPW'(MaxEmit)) ? FieldW'(MaxEmit) : FieldW'(count);

  // Status back to the controller.
  always_comb begin
    st.root_end   = (root >= neff);
    st.root_seen  = (disc[root[NW-1:0]] != '0);
    st.scan_end   = (x >= neff);
    st.scan_hit   = adj[v][xi];
    st.depth_zero = (depth == '0);
    st.find_hit   = bmark[lo][hi];
    st.emit_zero  = (emitted == '0);
    st.emit_last  = (k == emitted);
  end

  assign bridge_count = emitted;
  assign low_end      = FieldW'(lo);
  assign high_end     = FieldW'(hi);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CountW'(32);
    end else if (cfg_we) begin
      node_count <= cfg_value;
    end
  end

  // Adjacency matrix: set on edge beats, cleared after each run.
  always_ff @(posedge clk) begin
    if (rst || op == OP_CLEAR) begin
      for (int i = 0; i < NODES; i++) adj[i] <= '0;
    end else if (op == OP_ADD && a_ok && b_ok) begin
      adj[NW'(node_a)][NW'(node_b)] <= 1'b1;
      adj[NW'(node_b)][NW'(node_a)] <= 1'b1;
    end
  end

  // Search sequencing and bridge counting.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        bmark[i] <= '0;
        disc[i]  <= '0;
      end
      depth <= '0;
      tcnt  <= '0;
      root  <= '0;
      count <= '0;
    end else begin
      case (op)
        OP_INIT: begin
          for (int i = 0; i < NODES; i++) begin
            bmark[i] <= '0;
            disc[i]  <= '0;
          end
          tcnt  <= '0;
          root  <= '0;
          count <= '0;
          depth <= '0;
        end
        OP_ROOT: begin
          if (st.root_seen) begin
            root <= root + CW'(1);
          end else begin
            disc[root[NW-1:0]] <= tcnt + CW'(1);
            low[root[NW-1:0]]  <= tcnt + CW'(1);
            tcnt               <= tcnt + CW'(1);
            snode[0]           <= root[NW-1:0];
            spar[0]            <= root[NW-1:0];
            sscan[0]           <= '0;
            depth              <= CW'(1);
          end
        end
        OP_LOAD: begin
          top <= u;
          v   <= snode[u];
          par <= spar[u];
          x   <= sscan[u];
        end
        OP_SCAN: begin
          if (st.scan_end) begin
            depth <= depth - CW'(1);
          end else if (!st.scan_hit) begin
            x <= x + CW'(1);
          end else begin
            sscan[top] <= x + CW'(1);
            if (disc[xi] == '0) begin
              disc[xi] <= tcnt + CW'(1);
              low[xi]  <= tcnt + CW'(1);
              tcnt     <= tcnt + CW'(1);
              if (depth < CW'(NODES)) begin
                snode[depth[NW-1:0]] <= xi;
                spar[depth[NW-1:0]]  <= v;
                sscan[depth[NW-1:0]] <= '0;
                depth                <= depth + CW'(1);
              end
            end else if (xi != par && disc[xi] < low[v]) begin
              low[v] <= disc[xi];
            end
          end
        end
        OP_POP: begin
          if (depth == '0) begin
            root <= root + CW'(1);
          end else begin
            if (low[v] < low[snode[u]]) begin
              low[snode[u]] <= low[v];
            end
            if (low[v] > disc[snode[u]]) begin
              if (snode[u] < v) begin
                if (!bmark[snode[u]][v]) count <= count + CW'(1);
                bmark[snode[u]][v] <= 1'b1;
              end else begin
                if (!bmark[v][snode[u]]) count <= count + CW'(1);
                bmark[v][snode[u]] <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Emission pointers walk the bridge matrix in row order.
  always_ff @(posedge clk) begin
    case (op)
      OP_HDR_NEXT: begin
        lo <= '0;
        hi <= '0;
        k  <= FieldW'(1);
      end
      OP_FIND, OP_BR_NEXT: begin
        if (op == OP_BR_NEXT) k <= k + FieldW'(1);
        if (hi == NW'(NODES - 1)) begin
          hi <= '0;
          lo <= lo + NW'(1);
        end else begin
          hi <= hi + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/graph_bridge_finder.sv
// Top level of the graph bridge finder.
// Depends on gbf_pkg, gbf_ctrl and gbf_datapath.
`timescale 1ns / 1ps

// Edge beats (tuser = 0) load one undirected edge each and are taken one per
// cycle while the block is idle. A run beat (tuser = 1) starts a depth-first
// bridge search that holds s_tready low until all results are out and the
// graph is cleared. The search examines one adjacency bit per cycle, and every
// set bit it finds sends it through a reload of the stack top. Emission then
// scans the bridge matrix one bit per cycle, up to the last bridge, and holds
// while a result beat waits for m_tready. The run delivers a header beat with
// the bridge count, then one beat per bridge in ascending order, with tlast on
// the final beat, then clears the graph. node_count must be written on the cfg
// channel only while the block is idle; the block itself does not enforce it.
module graph_bridge_finder import gbf_pkg::*; #(
  parameter int NODES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // node_a[4:0], node_b[9:5], zero pad
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bridge_count[4:0], low_end[9:5], high_end[14:10]
  output logic        m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  dp_op_t            op;
  dp_status_t        st;
  logic [FieldW-1:0] bcount, lo_e, hi_e;

  assign cfg_ready = 1'b1;

  gbf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_run     (s_tuser),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_bridge (m_tuser),
    .out_ready  (m_tready),
    .st         (st),
    .op         (op)
  );

  gbf_datapath #(.NODES(NODES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .node_a       (s_tdata[4:0]),
    .node_b       (s_tdata[9:5]),
    .cfg_we       (cfg_valid),
    .cfg_value    (cfg_data),
    .st           (st),
    .bridge_count (bcount),
    .low_end      (lo_e),
    .high_end     (hi_e)
  );

  // Header beats carry only the count; bridge beats only the endpoints.
  always_comb begin
    if (m_tuser) begin
      m_tdata = {1'b0, hi_e, lo_e, 5'd0};
      m_tlast = st.emit_last;
    end else begin
      m_tdata = {11'd0, bcount};
      m_tlast = st.emit_zero;
    end
  end

endmodule

### bench/graph_bridge_finder_tb.sv
// Self-checking testbench for graph_bridge_finder.
// Predicts the bridge list of each loaded graph and checks every output beat.
// Depends on gbf_pkg and the graph_bridge_finder RTL.
`timescale 1ns / 1ps

module graph_bridge_finder_tb;
  import gbf_pkg::*;

  localparam int NODES = 32;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic       kind;
    logic [4:0] count;
    logic [4:0] lo;
    logic [4:0] hi;
    logic       last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  // Bench copy of the graph and register.
  logic [NODES-1:0] graph_adj [NODES];
  logic [5:0]       node_count_q;
  beat_t            bridge_beats [$];
  int               errors = 0;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  graph_bridge_finder #(.NODES(NODES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Iterative depth-first search that queues the expected header and bridges.
  task automatic predict_bridges();
    logic [NODES-1:0] marks [NODES];
    logic [5:0] disc [NODES];
    logic [5:0] lowl [NODES];
    int st_node [NODES];
    int st_par [NODES];
    int st_pos [NODES];
    int n, clock_t, depth, top, v, x, u, total, k;
    beat_t b;
    n = (node_count_q > NODES) ? NODES : node_count_q;
    clock_t = 0;
    total = 0;
    for (int i = 0; i < NODES; i++) begin
      marks[i] = '0;
      disc[i] = '0;
      lowl[i] = '0;
    end
    for (int r = 0; r < n; r++) begin
      if (disc[r] != 0) continue;
      clock_t++;
      disc[r] = 6'(clock_t);
      lowl[r] = 6'(clock_t);
      st_node[0] = r; st_par[0] = r; st_pos[0] = 0;
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        v = st_node[top];
        x = st_pos[top];
        while (x < n && !graph_adj[v][x]) x++;
        if (x < n) begin
          st_pos[top] = x + 1;
          if (disc[x] == 0) begin
            clock_t++;
            disc[x] = 6'(clock_t);
            lowl[x] = 6'(clock_t);
            if (depth < NODES) begin
              st_node[depth] = x; st_par[depth] = v; st_pos[depth] = 0;
              depth++;
            end
          end else if (x != st_par[top] && disc[x] < lowl[v]) begin
            lowl[v] = disc[x];
          end
        end else begin
          depth--;
          if (depth > 0) begin
            u = st_node[depth-1];
            if (lowl[v] < lowl[u]) lowl[u] = lowl[v];
            if (lowl[v] > disc[u]) begin
              if (u < v) marks[u][v] = 1'b1;
              else marks[v][u] = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        if (marks[i][j]) total++;
    if (total > MaxEmit) total = MaxEmit;
    b = '{kind: 1'b0, count: total[4:0], lo: '0, hi: '0, last: total == 0};
    bridge_beats.push_back(b);
    k = 1;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        if (marks[i][j] && k <= total) begin
          b = '{kind: 1'b1, count: '0, lo: i[4:0], hi: j[4:0], last: k == total};
          bridge_beats.push_back(b);
          k++;
        end
    for (int i = 0; i < NODES; i++) graph_adj[i] = '0;
  endtask

  // Sends one beat and updates the prediction on acceptance. Valid stays high
  // afterward so that the next beat can follow at once; idle cycles drop it.
  task automatic send_item(input logic cmd, input logic [4:0] a, input logic [4:0] b);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, b, a};
    do @(posedge clk); while (!s_tready);
    n = (node_count_q > NODES) ? NODES : node_count_q;
    if (cmd) predict_bridges();
    else if (a < n && b < n) begin
      graph_adj[a][b] = 1'b1;
      graph_adj[b][a] = 1'b1;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bridge_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [5:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_count_q = value;
  endtask

  // Receiver: random stalls and comparison of each accepted result beat.
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, count: m_tdata[4:0], lo: m_tdata[9:5],
              hi: m_tdata[14:10], last: m_tlast};
      if (bridge_beats.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
      end else begin
        want = bridge_beats.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d got %0d", want.kind, got.kind); errors++;
        end
        if (got.count != want.count) begin
          $error("bridge_count: expected %0d got %0d", want.count, got.count); errors++;
        end
        if (got.lo != want.lo) begin
          $error("low_end: expected %0d got %0d", want.lo, got.lo); errors++;
        end
        if (got.hi != want.hi) begin
          $error("high_end: expected %0d got %0d", want.hi, got.hi); errors++;
        end
        if (got.last != want.last) begin
          $error("last: expected %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic add_chain(input int first, input int len);
    for (int i = first; i < first + len - 1; i++) send_item(1'b0, i[4:0], 5'(i + 1));
  endtask

  // Directed graphs: extremes, self loop, duplicates, cycles, trees.
  task automatic test_directed();
    send_item(1'b1, 5'd0, 5'd0);             // empty graph
    send_item(1'b0, 5'd0, 5'd31);            // extreme ids, bridge 0-31
    send_item(1'b0, 5'd31, 5'd0);            // duplicate edge
    send_item(1'b0, 5'd5, 5'd5);             // self loop
    send_item(1'b1, 5'd31, 5'd31);
    add_chain(0, 4);
    send_item(1'b0, 5'd3, 5'd0);             // closes a cycle
    send_item(1'b0, 5'd3, 5'd10);
    send_item(1'b0, 5'd10, 5'd10);
    send_item(1'b1, 5'd0, 5'd0);
    for (int i = 1; i < 32; i++) send_item(1'b0, 5'd0, i[4:0]); // star
    send_item(1'b1, 5'd0, 5'd0);
    add_chain(0, 32);                          // path of 31 bridges
    send_item(1'b1, 5'd0, 5'd0);
  endtask

  task automatic test_node_count();
    write_node_count(6'd0);
    send_item(1'b0, 5'd0, 5'd1);
    send_item(1'b1, 5'd0, 5'd0);
    write_node_count(6'd63);                   // saturates at NODES
    add_chain(28, 4);
    send_item(1'b1, 5'd0, 5'd0);
    write_node_count(6'd8);
    send_item(1'b0, 5'd7, 5'd8);               // out of range
    send_item(1'b0, 5'd6, 5'd7);
    send_item(1'b1, 5'd0, 5'd0);
    // Edges loaded at one count, searched at a smaller one.
    write_node_count(6'd8);
    add_chain(2, 6);
    write_node_count(6'd5);
    send_item(1'b1, 5'd0, 5'd0);
    write_node_count(6'd1);
    send_item(1'b0, 5'd0, 5'd0);
    send_item(1'b1, 5'd0, 5'd0);
  endtask

  // Random graphs: sparse random edges within node_count, some noise edges.
  task automatic test_random(input int items);
    int sent, n, e;
    logic [4:0] a, b;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? 32 : $urandom_range(2, 16);
      write_node_count(($urandom_range(15) == 0) ? 6'($urandom_range(33, 63)) : n[5:0]);
      e = $urandom_range(1, 12);
      for (int i = 0; i < e; i++) begin
        if ($urandom_range(4) == 0) begin
          a = 5'($urandom); b = 5'($urandom);
        end else begin
          a = 5'($urandom_range(n - 1));
          b = 5'($urandom_range(n - 1));
        end
        send_item(1'b0, a, b);
      end
      send_item(1'b1, 5'($urandom), 5'($urandom));
      sent += e + 1;
    end
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) graph_adj[i] = '0;
    node_count_q = 6'd32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_node_count();
    test_random(3);
    send_idle_pct = 70;
    test_random(3);
    send_idle_pct = 0; recv_stall_pct = 70;
    test_random(3);
    send_idle_pct = 29; recv_stall_pct = 29;
    test_random(3);
    write_node_count(6'd32);
    wait_drained();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### graph_bridge_finder.f
src/gbf_pkg.sv
src/gbf_ctrl.sv
src/gbf_datapath.sv
src/graph_bridge_finder.sv
bench/graph_bridge_finder_tb.sv
